### sv/sleep_deadline_wakeup_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sleep deadline wake-up queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLEEP_DEADLINE_WAKEUP_QUEUE_UNIT_ASSERT_SVH
`define SLEEP_DEADLINE_WAKEUP_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication
`define SDWQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDWQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sdwq_pkg.sv
// ----------------------------------------------------------------------------
// sdwq_pkg
// Types and constants shared by the deadline queue cells and the top level.
// ----------------------------------------------------------------------------
package sdwq_pkg;

  localparam int TICK_W   = 63;
  localparam int DL_W     = 64;
  localparam int DUR_W    = 32;
  localparam int OUT_ID_W = 8;

  localparam logic [DL_W-1:0] DL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Input item kinds
  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Result kinds
  localparam logic [1:0] RK_ACCEPT = 2'd0;
  localparam logic [1:0] RK_REJECT = 2'd1;
  localparam logic [1:0] RK_WOKEN  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [DL_W-1:0] key;   // signed deadline to compare against
  } cell_ctl_t;

endpackage

### sv/sdwq_cell.sv
// ----------------------------------------------------------------------------
// sdwq_cell
// One slot of the sorted queue: holds a thread and its deadline, compares
// against the broadcast key and trades entries with its neighbours.
// ----------------------------------------------------------------------------
`include "sleep_deadline_wakeup_queue_unit_assert.svh"

module sdwq_cell import sdwq_pkg::*; #(
  parameter int IdW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctl_t       ctl,
  input  logic [IdW-1:0]  ins_id,
  // left neighbour (nearer the head)
  input  logic            prev_valid,
  input  logic            prev_le,
  input  logic [IdW-1:0]  prev_thread,
  input  logic [DL_W-1:0] prev_deadline,
  // right neighbour (nearer the tail)
  input  logic            next_valid,
  input  logic [IdW-1:0]  next_thread,
  input  logic [DL_W-1:0] next_deadline,
  output logic            valid,
  output logic            le,
  output logic [IdW-1:0]  thread,
  output logic [DL_W-1:0] deadline
);

  logic            valid_r, valid_nxt;
  logic [IdW-1:0]  thread_r, thread_nxt;
  logic [DL_W-1:0] deadline_r, deadline_nxt;

  // occupied and due at or before the key
  assign le = valid_r && ($signed(deadline_r) <= $signed(ctl.key));

  // insert opens a gap at the first later slot; shift pulls from the right
  always_comb begin
    valid_nxt    = valid_r;
    thread_nxt   = thread_r;
    deadline_nxt = deadline_r;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (!le) begin
          if (prev_le) begin
            valid_nxt    = 1'b1;
            thread_nxt   = ins_id;
            deadline_nxt = ctl.key;
          end else begin
            valid_nxt    = prev_valid;
            thread_nxt   = prev_thread;
            deadline_nxt = prev_deadline;
          end
        end
      end
      CELL_SHIFT: begin
        valid_nxt    = next_valid;
        thread_nxt   = next_thread;
        deadline_nxt = next_deadline;
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thread_r   <= thread_nxt;
    deadline_r <= deadline_nxt;
  end

  assign valid    = valid_r;
  assign thread   = thread_r;
  assign deadline = deadline_r;

  // occupied slots form a prefix and stay in deadline order; a shift
  // pulls the right neighbour's occupancy
  `SDWQ_ASSERT_IMP(a_cell_prefix, valid_r, prev_valid, "cell occupied behind an empty slot")
  `SDWQ_ASSERT_IMP(a_cell_order, valid_r && next_valid,
                   $signed(deadline_r) <= $signed(next_deadline), "queue out of order")
  `SDWQ_ASSERT_NXT(a_cell_shift, ctl.op == CELL_SHIFT, valid_r == $past(next_valid),
                   "shift did not pull the right neighbour")

endmodule

### sv/sleep_deadline_wakeup_queue_unit.sv
// ----------------------------------------------------------------------------
// sleep_deadline_wakeup_queue_unit
// Tick counter with a deadline-sorted queue of sleeping threads, held in a
// chain of cells; ticks release every thread that has come due.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_kind, in_thread_id, in_sleep_ticks
// out_     output     out_valid/out_stall  out_result_kind, out_woken_id,
//                                          out_tick_now, out_last
//
// A sleep first registers the saturated deadline, then makes one insert into
// the chain. A tick first advances the counter, then pops each due thread from
// the head cell in turn; a tick with none due gives no result.
// Reset clears the counter, the slot valid flags and the controller; no sweep.
// A stalled output holds the chain until the result register is free; the
// input is taken again as soon as the chain work of the item is done.
// ----------------------------------------------------------------------------
`include "sleep_deadline_wakeup_queue_unit_assert.svh"

module sleep_deadline_wakeup_queue_unit import sdwq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [OUT_ID_W-1:0]        in_thread_id,
  input  logic signed [DUR_W-1:0]    in_sleep_ticks,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_result_kind,
  output logic [OUT_ID_W-1:0]        out_woken_id,
  output logic [TICK_W-1:0]          out_tick_now,
  output logic                       out_last
);

  localparam int IdW = (ID_BITS < OUT_ID_W) ? ID_BITS : OUT_ID_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_POP    = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [DL_W-1:0]     dl_r, dl_nxt;
  logic [IdW-1:0]      sid_r, sid_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic [OUT_ID_W-1:0] out_id_r, out_id_nxt;
  logic [TICK_W-1:0]   out_tick_r, out_tick_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctl_t           ctl;
  logic [QUEUE_DEPTH-1:0] c_valid, c_le;
  logic [IdW-1:0]      c_thread   [QUEUE_DEPTH];
  logic [DL_W-1:0]     c_deadline [QUEUE_DEPTH];

  logic                in_xfer, out_free, full;
  logic [DL_W:0]       dl_sum;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = c_valid[QUEUE_DEPTH-1];

  // saturating deadline: counter is non-negative, so only upward overflow
  assign dl_sum = {2'b00, tick_r} + {{(DL_W+1-DUR_W){in_sleep_ticks[DUR_W-1]}}, in_sleep_ticks};

  // chain of slots
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic            p_valid, p_le, n_valid;
    logic [IdW-1:0]  p_thread, n_thread;
    logic [DL_W-1:0] p_deadline, n_deadline;

    if (gi == 0) begin : g_head
      assign p_valid    = 1'b1;
      assign p_le       = 1'b1;
      assign p_thread   = '0;
      assign p_deadline = '0;
    end else begin : g_body
      assign p_valid    = c_valid[gi-1];
      assign p_le       = c_le[gi-1];
      assign p_thread   = c_thread[gi-1];
      assign p_deadline = c_deadline[gi-1];
    end

    if (gi == QUEUE_DEPTH-1) begin : g_tail
      assign n_valid    = 1'b0;
      assign n_thread   = '0;
      assign n_deadline = '0;
    end else begin : g_mid
      assign n_valid    = c_valid[gi+1];
      assign n_thread   = c_thread[gi+1];
      assign n_deadline = c_deadline[gi+1];
    end

    sdwq_cell #(.IdW(IdW)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .ins_id        (sid_r),
      .prev_valid    (p_valid),
      .prev_le       (p_le),
      .prev_thread   (p_thread),
      .prev_deadline (p_deadline),
      .next_valid    (n_valid),
      .next_thread   (n_thread),
      .next_deadline (n_deadline),
      .valid         (c_valid[gi]),
      .le            (c_le[gi]),
      .thread        (c_thread[gi]),
      .deadline      (c_deadline[gi])
    );
  end

  // controller, chain command and result register
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    dl_nxt        = dl_r;
    sid_nxt       = sid_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;
    ctl.op        = CELL_HOLD;
    ctl.key       = {1'b0, tick_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_TICK) begin
            tick_nxt  = tick_r + 1'b1;
            state_nxt = ST_POP;
          end else begin
            dl_nxt    = (dl_sum[DL_W:DL_W-1] == 2'b01) ? DL_MAX : dl_sum[DL_W-1:0];
            sid_nxt   = in_thread_id[IdW-1:0];
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        ctl.key = dl_r;
        if (out_free) begin
          ctl.op        = full ? CELL_HOLD : CELL_INSERT;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = full ? RK_REJECT : RK_ACCEPT;
          out_id_nxt    = OUT_ID_W'(sid_r);
          out_tick_nxt  = tick_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!c_le[0]) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ctl.op        = CELL_SHIFT;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RK_WOKEN;
          out_id_nxt    = OUT_ID_W'(c_thread[0]);
          out_tick_nxt  = tick_r;
          out_last_nxt  = !c_le[1];
          if (!c_le[1]) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r       <= dl_nxt;
    sid_r      <= sid_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_tick_r <= out_tick_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_woken_id    = out_id_r;
  assign out_tick_now    = out_tick_r;
  assign out_last        = out_last_r;

  // tick advances the counter by one; inserts grow the queue by one;
  // sleep answers are always the final result
  `SDWQ_ASSERT_NXT(a_tick_step, in_xfer && (in_kind == KIND_TICK),
                   tick_r == $past(tick_r) + 1'b1, "tick counter did not advance by one")
  `SDWQ_ASSERT_NXT(a_insert_grow, ctl.op == CELL_INSERT,
                   $countones(c_valid) == $past($countones(c_valid)) + 1,
                   "insert did not add exactly one slot")
  `SDWQ_ASSERT_IMP(a_sleep_last, out_valid_r && (out_kind_r != RK_WOKEN), out_last_r,
                   "sleep answer without last")

endmodule

### tb/sv/sleep_deadline_wakeup_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sleep_deadline_wakeup_queue_unit_tb
// Drives sleep requests and timer ticks into the deadline queue and checks
// every result against a local model of the tick counter and sorted queue.
// Both channels idle at random, with one long output hold-off and one full
// drain pause along the way.
// ----------------------------------------------------------------------------
module sleep_deadline_wakeup_queue_unit_tb import sdwq_pkg::*; ();

  localparam int          QDEPTH         = 16;
  localparam int unsigned RANDOM_ITEMS   = 270;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        id;
    logic [TICK_W-1:0] tick_now;
    logic              last;
  } wake_result_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic                    in_kind        = KIND_SLEEP;
  logic [OUT_ID_W-1:0]     in_thread_id   = '0;
  logic signed [DUR_W-1:0] in_sleep_ticks = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [1:0]              out_result_kind;
  logic [OUT_ID_W-1:0]     out_woken_id;
  logic [TICK_W-1:0]       out_tick_now;
  logic                    out_last;

  // Local copy of the block state
  logic [TICK_W-1:0] tick_count = '0;
  int unsigned       sleepers   = 0;
  logic [7:0]        sleeper_id [QDEPTH];
  longint            sleeper_due[QDEPTH];

  wake_result_t due_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  items_offered  = 0;
  int unsigned  idle_cycles    = 0;

  // Idling controls
  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_seen      = 0;

  sleep_deadline_wakeup_queue_unit #(
    .QUEUE_DEPTH (QDEPTH),
    .ID_BITS     (8)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_thread_id    (in_thread_id),
    .in_sleep_ticks  (in_sleep_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_woken_id    (out_woken_id),
    .out_tick_now    (out_tick_now),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one accepted item to the local queue and queue up its results
  function automatic void advance_sleep_queue(logic kind, logic [7:0] id,
                                              logic signed [31:0] span);
    longint       now_l;
    longint       due;
    longint       dur;
    int unsigned  pos;
    int unsigned  woken;
    int unsigned  i;
    wake_result_t r;
    if (kind == KIND_SLEEP) begin
      r.id       = id;
      r.tick_now = tick_count;
      r.last     = 1'b1;
      if (sleepers >= QDEPTH) begin
        r.kind = RK_REJECT;
      end else begin
        now_l = longint'({1'b0, tick_count});
        dur   = longint'(span);
        // saturate rather than wrap past the largest signed deadline
        if (dur > 0 && now_l > longint'(DL_MAX) - dur)
          due = longint'(DL_MAX);
        else
          due = now_l + dur;
        // equal deadlines keep arrival order
        pos = 0;
        while (pos < sleepers && sleeper_due[pos] <= due)
          pos++;
        for (i = sleepers; i > pos; i--) begin
          sleeper_id[i]  = sleeper_id[i-1];
          sleeper_due[i] = sleeper_due[i-1];
        end
        sleeper_id[pos]  = id;
        sleeper_due[pos] = due;
        sleepers++;
        r.kind = RK_ACCEPT;
      end
      due_results.push_back(r);
    end else begin
      tick_count = tick_count + 1'b1;
      now_l      = longint'({1'b0, tick_count});
      woken      = 0;
      while (woken < sleepers && sleeper_due[woken] <= now_l) begin
        r.kind     = RK_WOKEN;
        r.id       = sleeper_id[woken];
        r.tick_now = tick_count;
        r.last     = !(woken + 1 < sleepers && sleeper_due[woken+1] <= now_l);
        due_results.push_back(r);
        woken++;
      end
      for (i = 0; i + woken < sleepers; i++) begin
        sleeper_id[i]  = sleeper_id[i+woken];
        sleeper_due[i] = sleeper_due[i+woken];
      end
      sleepers = sleepers - woken;
    end
  endfunction

  // Mostly short waits, some negative, now and then a random negative
  function automatic logic signed [31:0] pick_sleep_span();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)
      return 32'($urandom_range(0, 24));
    else if (sel <= 7)
      return -32'($urandom_range(1, 20));
    else if (sel == 8)
      return {1'b1, 31'($urandom)};
    return 32'sd0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // One input transfer, preceded by a random gap unless the sender is quiet
  task automatic send_item(input logic kind, input logic [7:0] id,
                           input logic signed [31:0] span);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_thread_id   <= id;
    in_sleep_ticks <= span;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sleep_queue(kind, id, span);
    items_offered++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of id and duration, negative and zero waits
  task automatic test_basic_wakeups();
    send_item(KIND_SLEEP, 8'h00, 32'sd1);
    send_item(KIND_TICK, 8'hFF, 32'sh7FFF_FFFF);
    send_item(KIND_SLEEP, 8'hFF, -32'sd1);
    send_item(KIND_SLEEP, 8'hAA, 32'sh8000_0000);
    send_item(KIND_SLEEP, 8'h55, 32'sd0);
    send_item(KIND_TICK, 8'h00, 32'sd0);
  endtask

  // Equal deadlines wake in arrival order; first tick has nothing due
  task automatic test_equal_deadlines();
    send_item(KIND_SLEEP, 8'h10, 32'sd3);
    send_item(KIND_SLEEP, 8'h11, 32'sd3);
    send_item(KIND_SLEEP, 8'h12, 32'sd2);
    repeat (3) send_item(KIND_TICK, 8'($urandom), 32'($urandom));
  endtask

  // Fill every slot, get two rejects, then wake the lot on one tick
  task automatic test_queue_full();
    repeat (QDEPTH) send_item(KIND_SLEEP, 8'($urandom), 32'sd1);
    repeat (2) send_item(KIND_SLEEP, 8'($urandom), pick_sleep_span());
    send_item(KIND_TICK, 8'($urandom), 32'($urandom));
  endtask

  // Long output hold-off with the sender pushing hard, then a full drain
  task automatic test_output_holdoff();
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    hold_asked++;
    repeat (12) begin
      send_item(KIND_SLEEP, 8'($urandom), 32'sd1);
      send_item(KIND_TICK, 8'($urandom), 32'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned shape;
    int unsigned n_sleep;
    int unsigned n_tick;
    start = items_offered;
    while (items_offered - start < RANDOM_ITEMS) begin
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      shape          = $urandom_range(0, 9);
      if (shape == 0) begin
        // scattered items of either kind
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 8'($urandom), pick_sleep_span());
      end else begin
        // a burst of sleeps, long ones overrun the queue
        n_sleep = (shape == 1) ? $urandom_range(12, 18) : $urandom_range(1, 5);
        n_tick  = (shape == 1) ? $urandom_range(0, 3) : $urandom_range(1, 6);
        repeat (n_sleep) send_item(KIND_SLEEP, 8'($urandom), pick_sleep_span());
        repeat (n_tick) send_item(KIND_TICK, 8'($urandom), 32'($urandom));
      end
    end
  endtask

  // Deadlines far in the future stay queued; run last for that reason
  task automatic test_far_deadlines();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    while (sleepers != 0) send_item(KIND_TICK, 8'($urandom), 32'($urandom));
    send_item(KIND_SLEEP, 8'h3C, 32'sh7FFF_FFFF);
    send_item(KIND_SLEEP, 8'hC3, 32'sh4000_0001);
    send_item(KIND_SLEEP, 8'h99, 32'sd0);
    send_item(KIND_TICK, 8'($urandom), 32'($urandom));
    send_item(KIND_TICK, 8'($urandom), 32'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_wakeups();
    test_equal_deadlines();
    test_queue_full();
    test_output_holdoff();
    test_random_traffic();
    test_far_deadlines();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output stall: random wait after each transfer, plus the long hold-off
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      stall_left = receiver_quiet ? 0 : $urandom_range(0, 15);
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_result
    wake_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none due, kind", '0, 64'(out_result_kind));
      end else begin
        head = due_results.pop_front();
        if (out_result_kind !== head.kind)
          report_mismatch("result_kind", 64'(head.kind), 64'(out_result_kind));
        if (out_woken_id !== head.id)
          report_mismatch("woken_id", 64'(head.id), 64'(out_woken_id));
        if (out_tick_now !== head.tick_now)
          report_mismatch("tick_now", 64'(head.tick_now), 64'(out_tick_now));
        if (out_last !== head.last)
          report_mismatch("last", 64'(head.last), 64'(out_last));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

### sim.f
+incdir+sv
sv/sdwq_pkg.sv
sv/sdwq_cell.sv
sv/sleep_deadline_wakeup_queue_unit.sv
tb/sv/sleep_deadline_wakeup_queue_unit_tb.sv
